// ===== rtl/bit_vector_engine_defines.svh =====
// Assertion macros for the bit vector engine.
// Depends on a clk_i clock and an rst_ni active-low reset in the including module.
`ifndef BIT_VECTOR_ENGINE_DEFINES_SVH
`define BIT_VECTOR_ENGINE_DEFINES_SVH

`define BVE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define BVE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bve_pkg.sv =====
// Shared constants, command types and word helper functions of the bit vector engine.
// Has no dependencies; used by all engine modules.
`default_nettype none

package bve_pkg;

  localparam int NUM_WORDS     = 64;
  localparam int WORD_W        = 64;
  localparam int WORD_IDX_W    = 6;
  localparam int BIT_POS_W     = 6;
  localparam int POP_W         = 7;
  localparam int OP_W          = 4;
  localparam int INDEX_W       = 12;
  localparam int ANSWER_W      = 13;
  localparam int ACTIVE_W      = 7;
  localparam int DATA_W        = 32;
  localparam int ADDR_W        = 2;
  localparam int CMD_DEPTH     = 2;
  localparam int CMD_PTR_W     = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W     = $clog2(CMD_DEPTH + 1);

  localparam logic [ADDR_W-1:0]   REG_ACTIVE_WORDS   = 2'd0;
  localparam logic [ACTIVE_W-1:0] ACTIVE_WORDS_RESET = 7'd64;

  typedef enum logic [OP_W-1:0] {
    OP_SET_BIT   = 4'd0,
    OP_CLEAR_BIT = 4'd1,
    OP_FLIP_BIT  = 4'd2,
    OP_TEST_BIT  = 4'd3,
    OP_FILL_ALL  = 4'd4,
    OP_CLEAR_ALL = 4'd5,
    OP_INVERT    = 4'd6,
    OP_ANY       = 4'd7,
    OP_COUNT     = 4'd8,
    OP_FIND      = 4'd9
  } op_e;

  typedef enum logic [3:0] {
    K_SET,
    K_CLR,
    K_FLIP,
    K_TEST,
    K_FILL,
    K_ZERO,
    K_INV,
    K_ANY,
    K_COUNT,
    K_FIND,
    K_NONE
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e              kind;
    logic                   err;
    logic [WORD_IDX_W-1:0]  word;
    logic [BIT_POS_W-1:0]   bitpos;
  } cmd_t;

  function automatic logic [POP_W-1:0] popcount64(input logic [WORD_W-1:0] w);
    logic [1:0] s1 [32];
    logic [2:0] s2 [16];
    logic [3:0] s3 [8];
    logic [4:0] s4 [4];
    logic [5:0] s5 [2];
    for (int i = 0; i < 32; i++) s1[i] = {1'b0, w[2*i]} + {1'b0, w[2*i+1]};
    for (int i = 0; i < 16; i++) s2[i] = {1'b0, s1[2*i]} + {1'b0, s1[2*i+1]};
    for (int i = 0; i < 8; i++)  s3[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
    for (int i = 0; i < 4; i++)  s4[i] = {1'b0, s3[2*i]} + {1'b0, s3[2*i+1]};
    for (int i = 0; i < 2; i++)  s5[i] = {1'b0, s4[2*i]} + {1'b0, s4[2*i+1]};
    return {1'b0, s5[0]} + {1'b0, s5[1]};
  endfunction

  // Binary search for the lowest set bit; returns 63 for an all-zero word.
  function automatic logic [BIT_POS_W-1:0] lowest_set64(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0]    x;
    logic [WORD_W-1:0]    lo;
    logic [BIT_POS_W-1:0] pos;
    x   = w;
    pos = '0;
    for (int lvl = BIT_POS_W - 1; lvl >= 0; lvl--) begin
      lo = (WORD_W'(1) << (1 << lvl)) - WORD_W'(1);
      if ((x & lo) == '0) begin
        pos[lvl] = 1'b1;
        x        = x >> (1 << lvl);
      end
    end
    return pos;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bve_front.sv =====
// Front end of the bit vector engine: accepts transactions and classifies them into commands.
// Depends on bve_pkg.
`default_nettype none

module bve_front (
  input  wire logic                          push_i,
  output logic                               full_o,
  input  wire logic [bve_pkg::OP_W-1:0]      operation_i,
  input  wire logic [bve_pkg::INDEX_W-1:0]   bit_index_i,
  input  wire logic [bve_pkg::WORD_IDX_W-1:0] last_word_i,
  input  wire logic                          fifo_full_i,
  output logic                               cmd_push_o,
  output bve_pkg::cmd_t                      cmd_o
);
  import bve_pkg::*;

  logic in_range;
  logic bit_op;

  always_comb begin
    in_range   = bit_index_i[INDEX_W-1:BIT_POS_W] <= last_word_i;
    bit_op     = 1'b1;
    cmd_o.word   = bit_index_i[INDEX_W-1:BIT_POS_W];
    cmd_o.bitpos = bit_index_i[BIT_POS_W-1:0];
    cmd_o.err    = 1'b0;
    cmd_o.kind   = K_NONE;
    case (operation_i)
      OP_SET_BIT:   cmd_o.kind = K_SET;
      OP_CLEAR_BIT: cmd_o.kind = K_CLR;
      OP_FLIP_BIT:  cmd_o.kind = K_FLIP;
      OP_TEST_BIT:  cmd_o.kind = K_TEST;
      OP_FILL_ALL: begin
        cmd_o.kind = K_FILL;
        bit_op     = 1'b0;
      end
      OP_CLEAR_ALL: begin
        cmd_o.kind = K_ZERO;
        bit_op     = 1'b0;
      end
      OP_INVERT: begin
        cmd_o.kind = K_INV;
        bit_op     = 1'b0;
      end
      OP_ANY: begin
        cmd_o.kind = K_ANY;
        bit_op     = 1'b0;
      end
      OP_COUNT: begin
        cmd_o.kind = K_COUNT;
        bit_op     = 1'b0;
      end
      OP_FIND: begin
        cmd_o.kind = K_FIND;
        bit_op     = 1'b0;
      end
      default: begin
        cmd_o.kind = K_NONE;
        bit_op     = 1'b0;
      end
    endcase
    if (bit_op && !in_range) begin
      cmd_o.kind = K_NONE;
      cmd_o.err  = 1'b1;
    end
    cmd_push_o = push_i && !fifo_full_i;
    full_o     = fifo_full_i;
  end

endmodule

`default_nettype wire

// ===== rtl/bve_cmd_fifo.sv =====
// Short command queue between the front end and the execution unit.
// Depends on bve_pkg.
`default_nettype none

module bve_cmd_fifo (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire bve_pkg::cmd_t data_i,
  output logic         full_o,
  input  wire logic    pop_i,
  output logic         empty_o,
  output bve_pkg::cmd_t data_o
);
  import bve_pkg::*;

  cmd_t                 slot_q [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CMD_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CMD_CNT_W-1:0] count_q, count_d;
  logic                 do_push;
  logic                 do_pop;

  always_comb begin
    full_o   = count_q == CMD_CNT_W'(CMD_DEPTH);
    empty_o  = count_q == '0;
    do_push  = push_i && !full_o;
    do_pop   = pop_i && !empty_o;
    data_o   = slot_q[rd_ptr_q];
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bve_back.sv =====
// Execution unit of the bit vector engine: word store, read-modify-write and scan sequencer,
// and the result register. Depends on bve_pkg and bit_vector_engine_defines.svh.
`default_nettype none
`include "bit_vector_engine_defines.svh"

module bve_back (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic [bve_pkg::WORD_IDX_W-1:0] last_word_i,
  input  wire logic                           cmd_empty_i,
  input  wire bve_pkg::cmd_t                  cmd_i,
  output logic                                cmd_pop_o,
  output logic                                res_empty_o,
  input  wire logic                           res_pop_i,
  output logic [bve_pkg::ANSWER_W-1:0]        answer_o,
  output logic                                index_error_o
);
  import bve_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN
  } state_e;

  state_e                 state_q, state_d;
  cmd_t                   cmd_q, cmd_d;
  logic                   found_q, found_d;
  logic [ANSWER_W-1:0]    count_q, count_d;
  logic [ANSWER_W-1:0]    pos_q, pos_d;
  logic                   res_valid_q;
  logic [ANSWER_W-1:0]    res_answer_q;
  logic                   res_err_q;

  logic [WORD_W-1:0]      mem_q [NUM_WORDS];
  logic [NUM_WORDS-1:0]   valid_q;
  logic [WORD_W-1:0]      rd_data_q;
  logic                   rd_valid_q;
  logic [WORD_IDX_W-1:0]  rd_idx_q;

  logic                   rd_en;
  logic [WORD_IDX_W-1:0]  rd_addr;
  logic                   wr_en;
  logic [WORD_IDX_W-1:0]  wr_addr;
  logic [WORD_W-1:0]      wr_data;

  logic [WORD_W-1:0]      word;
  logic                   word_nz;
  logic [POP_W-1:0]       word_pop;
  logic [BIT_POS_W-1:0]   word_low;
  logic [WORD_W-1:0]      mask;
  logic                   slot_free;
  logic                   start;
  logic                   scan_last;
  logic [ANSWER_W-1:0]    empty_pos;
  logic                   res_load;
  logic [ANSWER_W-1:0]    res_answer;
  logic                   res_err;

  always_comb begin
    word      = rd_valid_q ? rd_data_q : '0;
    word_nz   = |word;
    word_pop  = popcount64(word);
    word_low  = lowest_set64(word);
    mask      = WORD_W'(1) << cmd_q.bitpos;
    slot_free = !res_valid_q || res_pop_i;
    start     = (state_q == S_IDLE) && !cmd_empty_i && slot_free;
    cmd_pop_o = start;
    scan_last = rd_idx_q == last_word_i;
    empty_pos = ANSWER_W'({1'b0, last_word_i} + (WORD_IDX_W + 1)'(1)) << BIT_POS_W;

    state_d    = state_q;
    cmd_d      = cmd_q;
    found_d    = found_q;
    count_d    = count_q;
    pos_d      = pos_q;
    rd_en      = 1'b0;
    rd_addr    = cmd_i.word;
    wr_en      = 1'b0;
    wr_addr    = rd_idx_q;
    wr_data    = word;
    res_load   = 1'b0;
    res_answer = '0;
    res_err    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_d = cmd_i;
          case (cmd_i.kind)
            K_SET, K_CLR, K_FLIP, K_TEST: begin
              rd_en   = 1'b1;
              state_d = S_EXEC;
            end
            K_FILL, K_ZERO, K_INV, K_ANY, K_COUNT, K_FIND: begin
              rd_en   = 1'b1;
              rd_addr = '0;
              found_d = 1'b0;
              count_d = '0;
              pos_d   = '0;
              state_d = S_SCAN;
            end
            default: begin
              res_load = 1'b1;
              res_err  = cmd_i.err;
            end
          endcase
        end
      end
      S_EXEC: begin
        res_load = 1'b1;
        state_d  = S_IDLE;
        wr_addr  = cmd_q.word;
        case (cmd_q.kind)
          K_SET: begin
            wr_en   = 1'b1;
            wr_data = word | mask;
          end
          K_CLR: begin
            wr_en   = 1'b1;
            wr_data = word & ~mask;
          end
          K_FLIP: begin
            wr_en   = 1'b1;
            wr_data = word ^ mask;
          end
          K_TEST: res_answer = ANSWER_W'(|(word & mask));
          default: ;
        endcase
      end
      S_SCAN: begin
        case (cmd_q.kind)
          K_FILL: begin
            wr_en   = 1'b1;
            wr_data = '1;
          end
          K_ZERO: begin
            wr_en   = 1'b1;
            wr_data = '0;
          end
          K_INV: begin
            wr_en   = 1'b1;
            wr_data = ~word;
          end
          K_ANY, K_FIND: begin
            if (!found_q && word_nz) begin
              found_d = 1'b1;
              pos_d   = ANSWER_W'({rd_idx_q, word_low});
            end
          end
          K_COUNT: count_d = count_q + ANSWER_W'(word_pop);
          default: ;
        endcase
        if (scan_last) begin
          res_load = 1'b1;
          state_d  = S_IDLE;
          case (cmd_q.kind)
            K_ANY:   res_answer = ANSWER_W'(found_d);
            K_COUNT: res_answer = count_d;
            K_FIND:  res_answer = found_d ? pos_d : empty_pos;
            default: res_answer = '0;
          endcase
        end else begin
          rd_en   = 1'b1;
          rd_addr = rd_idx_q + 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cmd_q        <= '0;
      found_q      <= 1'b0;
      count_q      <= '0;
      pos_q        <= '0;
      res_valid_q  <= 1'b0;
      res_answer_q <= '0;
      res_err_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cmd_q   <= cmd_d;
      found_q <= found_d;
      count_q <= count_d;
      pos_q   <= pos_d;
      if (res_load) begin
        res_valid_q  <= 1'b1;
        res_answer_q <= res_answer;
        res_err_q    <= res_err;
      end else if (res_pop_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_q[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_q <= valid_q[rd_addr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
      rd_idx_q  <= rd_addr;
    end
  end

  assign res_empty_o   = !res_valid_q;
  assign answer_o      = res_answer_q;
  assign index_error_o = res_err_q;

  `BVE_ASSERT_IMP(a_res_slot_free, res_load, !res_valid_q || res_pop_i, "result lost")
  `BVE_ASSERT_IMP(a_scan_bound, state_q == S_SCAN, rd_idx_q <= last_word_i, "scan beyond last word")
  `BVE_ASSERT_IMP(a_write_state, wr_en, state_q == S_EXEC || state_q == S_SCAN, "stray write")
  `BVE_ASSERT_NXT(a_exec_single, state_q == S_EXEC, state_q == S_IDLE, "bit update overran")

endmodule

`default_nettype wire

// ===== rtl/bit_vector_engine.sv =====
// Top level of the bit vector engine: configuration register, front end, command queue and
// execution unit. Depends on bve_pkg, bve_front, bve_cmd_fifo and bve_back.
//
//   Channel   Handshake              Payload
//   input     push / full            operation_i, bit_index_i
//   result    pop / empty            answer_o, index_error_o
//   config    psel penable pwrite    paddr, pwdata, prdata (active_words at address 0)
//
// Set, clear, flip and test read the word in the execution unit, then write it back (test
// checks the bit instead). Bulk operations and queries scan one word per cycle through the
// single store read port.
// Reset clears the word store through per-word valid bits, so no clearing pass is needed.
// A two-entry command queue keeps accepting transactions while a result waits to be popped.
`default_nettype none

module bit_vector_engine (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic [bve_pkg::OP_W-1:0]     operation_i,
  input  wire logic [bve_pkg::INDEX_W-1:0]  bit_index_i,
  output logic                              empty,
  input  wire logic                         pop,
  output logic [bve_pkg::ANSWER_W-1:0]      answer_o,
  output logic                              index_error_o,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [bve_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [bve_pkg::DATA_W-1:0]   pwdata,
  output logic [bve_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);
  import bve_pkg::*;

  logic [ACTIVE_W-1:0]   active_words_q;
  logic [WORD_IDX_W-1:0] last_word;
  logic                  cfg_write;
  logic                  fifo_full;
  logic                  fifo_empty;
  logic                  cmd_push;
  logic                  cmd_pop;
  cmd_t                  front_cmd;
  cmd_t                  queue_cmd;

  always_comb begin
    pready    = 1'b1;
    cfg_write = psel && penable && pwrite && pready && (paddr == REG_ACTIVE_WORDS);
    prdata    = (paddr == REG_ACTIVE_WORDS) ? DATA_W'(active_words_q) : '0;
    if (active_words_q == '0) begin
      last_word = '0;
    end else if (active_words_q > ACTIVE_W'(NUM_WORDS)) begin
      last_word = WORD_IDX_W'(NUM_WORDS - 1);
    end else begin
      last_word = WORD_IDX_W'(active_words_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_words_q <= ACTIVE_WORDS_RESET;
    end else if (cfg_write) begin
      active_words_q <= pwdata[ACTIVE_W-1:0];
    end
  end

  bve_front u_front (
    .push_i      (push),
    .full_o      (full),
    .operation_i (operation_i),
    .bit_index_i (bit_index_i),
    .last_word_i (last_word),
    .fifo_full_i (fifo_full),
    .cmd_push_o  (cmd_push),
    .cmd_o       (front_cmd)
  );

  bve_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (front_cmd),
    .full_o  (fifo_full),
    .pop_i   (cmd_pop),
    .empty_o (fifo_empty),
    .data_o  (queue_cmd)
  );

  bve_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .last_word_i   (last_word),
    .cmd_empty_i   (fifo_empty),
    .cmd_i         (queue_cmd),
    .cmd_pop_o     (cmd_pop),
    .res_empty_o   (empty),
    .res_pop_i     (pop),
    .answer_o      (answer_o),
    .index_error_o (index_error_o)
  );

endmodule

`default_nettype wire
